// File: src/ppnc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppnc_pkg
// Shared types, register codes and fixed widths of the projective vertex
// transform with near-plane clipping.
// ----------------------------------------------------------------------------
package ppnc_pkg;

    // datapath width of the shared adder, multiplier and divider
    localparam int WIDE       = 128;
    // homogeneous coordinate width
    localparam int HB         = 62;
    // multiplier operand width (signed) and step count
    localparam int MUL_STEPS  = 64;
    // divider step count
    localparam int DIV_STEPS  = 128;
    // near plane register width
    localparam int NEAR_W     = 17;
    // coefficient width
    localparam int COEF_W     = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_XX_XY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XO_YX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YY_YO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WX_WY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR   = 3'd5;

    // quotient stand-ins for a division by zero (saturate by numerator sign)
    localparam logic [WIDE-1:0] DZ_NEG = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    localparam logic [WIDE-1:0] DZ_POS = {64'h7FFF_FFFF_FFFF_FFFF, 64'h0};

    // saturated homogeneous value
    typedef struct packed {
        logic          ovf;
        logic [HB-1:0] val;
    } t_hsat;

    // saturate a wide two's complement value to HB signed bits
    function automatic t_hsat sat_homog(input logic [WIDE-1:0] v);
        t_hsat r;
        if ((&v[WIDE-1:HB-1]) || (~|v[WIDE-1:HB-1])) begin
            r.ovf = 1'b0;
            r.val = v[HB-1:0];
        end else begin
            r.ovf = 1'b1;
            r.val = v[WIDE-1] ? {1'b1, {(HB-1){1'b0}}} : {1'b0, {(HB-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/polygon_project_near_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_project_near_clip
// Projective 3x3 vertex transform with near-plane clipping, run on one
// shared 128-bit adder under a sequencer (shift-add multiply, restoring
// divide).
// ----------------------------------------------------------------------------
// Work: the transform takes six multiplies, a visible vertex two divides
//   and each crossing two multiplies and four divides.
// Flow: vertices are taken one at a time; s_axis_tready is high only when
//   the sequencer is idle. The last result may wait in the output register.
// Reset: synchronous, active low; configuration, sequencer and the previous
//   and first shape state return to their reset values, no result pending.

module polygon_project_near_clip #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int TDW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ppnc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]                   i_cfg_data,
    // vertex input
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [TDW-1:0]                s_axis_tdata,  // vert_x, vert_y
    input  wire logic [1:0]                    s_axis_tuser,  // first_vertex, closed_shape
    input  wire logic                          s_axis_tlast,  // last_vertex
    // result output
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [TDW-1:0]                     m_axis_tdata,  // out_x, out_y
    output logic [1:0]                         m_axis_tuser,  // from_clip, overflow
    output logic                               m_axis_tlast   // run_end
);
    import ppnc_pkg::*;

    localparam int CW = COORD_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE, S_HROW_A, S_HROW_B, S_HROW_C, S_HROW_D, S_CLASS, S_DISPATCH,
        S_XNUM, S_XDEN, S_XMUL, S_XDIV1, S_XADD, S_XDIV2, S_VX, S_RSAT, S_EMIT,
        S_MUL, S_DNEGN, S_DNEGD, S_DLOOP, S_DFIX
    } t_state;

    typedef struct packed {
        logic          ovf;
        logic [CW-1:0] val;
    } t_osat;

    // saturate a wide value to CW signed bits
    function automatic t_osat sat_out(input logic [WIDE-1:0] v);
        t_osat r;
        if ((&v[WIDE-1:CW-1]) || (~|v[WIDE-1:CW-1])) begin
            r.ovf = 1'b0;
            r.val = v[CW-1:0];
        end else begin
            r.ovf = 1'b1;
            r.val = v[WIDE-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration
    logic [63:0]       r_xx_xy, r_xo_yx, r_yy_yo, r_wx_wy;
    logic [COEF_W-1:0] r_wo;
    logic [NEAR_W-1:0] r_near;

    // sequencer
    t_state           r_state, r_ret;
    logic [1:0]       r_row;
    logic             r_j, r_xsel, r_isx;
    logic [6:0]       r_cnt;
    logic             r_c1, r_c2, r_c3;

    // captured vertex word
    logic [CW-1:0]    r_vx, r_vy;
    logic             r_first, r_last, r_closed;

    // shape state
    logic [HB-1:0]    r_cur_x, r_cur_y, r_cur_w;
    logic [HB-1:0]    r_prv_x, r_prv_y, r_prv_w;
    logic [HB-1:0]    r_fst_x, r_fst_y, r_fst_w;
    logic             r_cur_vis, r_prv_vis, r_fst_vis;
    logic             r_hov, r_prv_ovf, r_fst_ovf;

    // arithmetic unit registers
    logic [WIDE-1:0]  r_acc, r_mcand, r_quo, r_rem, r_dvs;
    logic [63:0]      r_mplier, r_num, r_den;
    logic             r_nsign, r_dneg;

    // result being built and output register
    logic [CW-1:0]    r_rx, r_ry, r_ox, r_oy;
    logic             r_rovf;
    logic             r_mvalid, r_oclip, r_oovf, r_olast;

    // shared adder
    logic [WIDE-1:0]  alu_a, alu_b;
    logic             alu_sub;
    logic [WIDE:0]    alu_sum;

    logic [COEF_W-1:0] row_a, row_b, row_c;
    logic [HB-1:0]    a_x, a_y, a_w, b_x, b_y, b_w, a_j, b_j, cur_j;
    logic [WIDE-1:0]  acc_sar, rem_sh, near_w, p_shl, vx_num;
    logic             cur_vis;
    t_hsat            hsat;
    t_osat            osat;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = TDW'({r_oy, r_ox});
    assign m_axis_tuser  = {r_oovf, r_oclip};
    assign m_axis_tlast  = r_olast;

    // matrix row select
    always_comb begin
        case (r_row)
            2'd0: begin
                row_a = r_xx_xy[63:32]; row_b = r_xx_xy[31:0]; row_c = r_xo_yx[63:32];
            end
            2'd1: begin
                row_a = r_xo_yx[31:0]; row_b = r_yy_yo[63:32]; row_c = r_yy_yo[31:0];
            end
            default: begin
                row_a = r_wx_wy[63:32]; row_b = r_wx_wy[31:0]; row_c = r_wo;
            end
        endcase
    end

    // edge endpoints: incoming edge prev->cur, closing edge cur->first
    assign a_x   = r_xsel ? r_cur_x : r_prv_x;
    assign a_y   = r_xsel ? r_cur_y : r_prv_y;
    assign a_w   = r_xsel ? r_cur_w : r_prv_w;
    assign b_x   = r_xsel ? r_fst_x : r_cur_x;
    assign b_y   = r_xsel ? r_fst_y : r_cur_y;
    assign b_w   = r_xsel ? r_fst_w : r_cur_w;
    assign a_j   = r_j ? a_y : a_x;
    assign b_j   = r_j ? b_y : b_x;
    assign cur_j = r_j ? r_cur_y : r_cur_x;

    assign acc_sar = WIDE'($signed(r_acc) >>> FRAC_BITS);
    assign rem_sh  = {r_rem[WIDE-2:0], r_quo[WIDE-1]};
    assign near_w  = {{(WIDE-NEAR_W){1'b0}}, r_near};
    assign p_shl   = r_acc << FRAC_BITS;
    assign vx_num  = {{(WIDE-HB){cur_j[HB-1]}}, cur_j} << FRAC_BITS;
    assign cur_vis = $signed({r_cur_w[HB-1], r_cur_w}) >=
                     $signed({{(HB+1-NEAR_W){1'b0}}, r_near});
    assign hsat    = sat_homog(r_acc);
    assign osat    = sat_out(r_quo);

    // shared adder operand select
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_MUL: begin
                alu_a   = r_acc;
                alu_b   = r_mcand;
                alu_sub = (r_cnt == 7'(MUL_STEPS - 1));  // sign bit weighs negative
            end
            S_DNEGN, S_DFIX: begin
                alu_b   = r_quo;
                alu_sub = 1'b1;
            end
            S_DNEGD: begin
                alu_b   = r_dvs;
                alu_sub = 1'b1;
            end
            S_DLOOP: begin
                alu_a   = rem_sh;
                alu_b   = r_dvs;
                alu_sub = 1'b1;
            end
            S_HROW_C: begin
                alu_a = acc_sar;
                alu_b = {{(WIDE-COEF_W){row_c[COEF_W-1]}}, row_c};
            end
            S_XNUM: begin
                alu_a   = {{(WIDE-HB){a_w[HB-1]}}, a_w};
                alu_b   = near_w;
                alu_sub = 1'b1;
            end
            S_XDEN: begin
                alu_a   = {{(WIDE-HB){a_w[HB-1]}}, a_w};
                alu_b   = {{(WIDE-HB){b_w[HB-1]}}, b_w};
                alu_sub = 1'b1;
            end
            S_XMUL: begin
                alu_a   = {{(WIDE-HB){b_j[HB-1]}}, b_j};
                alu_b   = {{(WIDE-HB){a_j[HB-1]}}, a_j};
                alu_sub = 1'b1;
            end
            S_XADD: begin
                alu_a = {{(WIDE-HB){a_j[HB-1]}}, a_j};
                alu_b = r_quo;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {WIDE{alu_sub}}} + {{WIDE{1'b0}}, alu_sub};

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_xx_xy   <= 64'd281474976710656;
            r_xo_yx   <= 64'd0;
            r_yy_yo   <= 64'd281474976710656;
            r_wx_wy   <= 64'd0;
            r_wo      <= 32'd65536;
            r_near    <= 17'd1311;
            r_row     <= '0;
            r_j       <= 1'b0;
            r_xsel    <= 1'b0;
            r_isx     <= 1'b0;
            r_cnt     <= '0;
            r_c1      <= 1'b0;
            r_c2      <= 1'b0;
            r_c3      <= 1'b0;
            r_prv_x   <= '0;
            r_prv_y   <= '0;
            r_prv_w   <= '0;
            r_fst_x   <= '0;
            r_fst_y   <= '0;
            r_fst_w   <= '0;
            r_prv_vis <= 1'b0;
            r_fst_vis <= 1'b0;
            r_prv_ovf <= 1'b0;
            r_fst_ovf <= 1'b0;
            r_mvalid  <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_XX_XY: r_xx_xy <= i_cfg_data;
                    CFG_XO_YX: r_xo_yx <= i_cfg_data;
                    CFG_YY_YO: r_yy_yo <= i_cfg_data;
                    CFG_WX_WY: r_wx_wy <= i_cfg_data;
                    CFG_WO:    r_wo    <= i_cfg_data[COEF_W-1:0];
                    CFG_NEAR:  r_near  <= i_cfg_data[NEAR_W-1:0];
                    default:   r_near  <= r_near;
                endcase
            end

            // output word taken; a word loaded in S_EMIT keeps it valid
            if (r_mvalid && m_axis_tready && (r_state != S_EMIT)) begin
                r_mvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_vx     <= s_axis_tdata[CW-1:0];
                        r_vy     <= s_axis_tdata[2*CW-1:CW];
                        r_first  <= s_axis_tuser[0];
                        r_closed <= s_axis_tuser[1];
                        r_last   <= s_axis_tlast;
                        r_hov    <= 1'b0;
                        r_row    <= '0;
                        r_state  <= S_HROW_A;
                    end
                end

                // transform: acc = a*x + b*y, then floor shift plus offset
                S_HROW_A: begin
                    r_acc    <= '0;
                    r_mcand  <= {{(WIDE-COEF_W){row_a[COEF_W-1]}}, row_a};
                    r_mplier <= {{(64-CW){r_vx[CW-1]}}, r_vx};
                    r_cnt    <= '0;
                    r_ret    <= S_HROW_B;
                    r_state  <= S_MUL;
                end
                S_HROW_B: begin
                    r_mcand  <= {{(WIDE-COEF_W){row_b[COEF_W-1]}}, row_b};
                    r_mplier <= {{(64-CW){r_vy[CW-1]}}, r_vy};
                    r_cnt    <= '0;
                    r_ret    <= S_HROW_C;
                    r_state  <= S_MUL;
                end
                S_HROW_C: begin
                    r_acc   <= alu_sum[WIDE-1:0];
                    r_state <= S_HROW_D;
                end
                S_HROW_D: begin
                    case (r_row)
                        2'd0:    r_cur_x <= hsat.val;
                        2'd1:    r_cur_y <= hsat.val;
                        default: r_cur_w <= hsat.val;
                    endcase
                    r_hov <= r_hov | hsat.ovf;
                    if (r_row == 2'd2) begin
                        r_state <= S_CLASS;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_HROW_A;
                    end
                end

                // visibility and the list of results to build
                S_CLASS: begin
                    r_cur_vis <= cur_vis;
                    r_c1      <= !r_first && (cur_vis != r_prv_vis);
                    r_c2      <= cur_vis;
                    r_c3      <= r_last && r_closed && !r_first && (cur_vis != r_fst_vis);
                    if (r_first) begin
                        r_fst_x   <= r_cur_x;
                        r_fst_y   <= r_cur_y;
                        r_fst_w   <= r_cur_w;
                        r_fst_vis <= cur_vis;
                        r_fst_ovf <= r_hov;
                    end
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    if (r_c1) begin
                        r_c1    <= 1'b0;
                        r_xsel  <= 1'b0;
                        r_isx   <= 1'b1;
                        r_state <= S_XNUM;
                    end else if (r_c2) begin
                        r_c2    <= 1'b0;
                        r_isx   <= 1'b0;
                        r_j     <= 1'b0;
                        r_rovf  <= r_hov;
                        r_state <= S_VX;
                    end else if (r_c3) begin
                        r_c3    <= 1'b0;
                        r_xsel  <= 1'b1;
                        r_isx   <= 1'b1;
                        r_state <= S_XNUM;
                    end else begin
                        r_prv_x   <= r_cur_x;
                        r_prv_y   <= r_cur_y;
                        r_prv_w   <= r_cur_w;
                        r_prv_vis <= r_cur_vis;
                        r_prv_ovf <= r_hov;
                        r_state   <= S_IDLE;
                    end
                end

                // crossing: P = A + (B - A) * (A.w - near) / (A.w - B.w)
                S_XNUM: begin
                    r_num   <= alu_sum[63:0];
                    r_rovf  <= r_hov | (r_xsel ? r_fst_ovf : r_prv_ovf);
                    r_j     <= 1'b0;
                    r_state <= S_XDEN;
                end
                S_XDEN: begin
                    r_den   <= alu_sum[63:0];
                    r_state <= S_XMUL;
                end
                S_XMUL: begin
                    r_mcand  <= alu_sum[WIDE-1:0];
                    r_mplier <= r_num;
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_ret    <= S_XDIV1;
                    r_state  <= S_MUL;
                end
                S_XDIV1: begin
                    r_quo   <= r_acc;
                    r_dvs   <= {{(WIDE-64){r_den[63]}}, r_den};
                    r_nsign <= r_acc[WIDE-1];
                    r_dneg  <= r_acc[WIDE-1] ^ r_den[63];
                    r_ret   <= S_XADD;
                    r_state <= S_DNEGN;
                end
                S_XADD: begin
                    r_acc   <= alu_sum[WIDE-1:0];
                    r_state <= S_XDIV2;
                end
                S_XDIV2: begin
                    r_quo   <= p_shl;
                    r_dvs   <= near_w;
                    r_nsign <= p_shl[WIDE-1];
                    r_dneg  <= p_shl[WIDE-1];
                    r_ret   <= S_RSAT;
                    r_state <= S_DNEGN;
                end

                // vertex: h * 2^frac / w
                S_VX: begin
                    r_quo   <= vx_num;
                    r_dvs   <= {{(WIDE-HB){r_cur_w[HB-1]}}, r_cur_w};
                    r_nsign <= vx_num[WIDE-1];
                    r_dneg  <= vx_num[WIDE-1] ^ r_cur_w[HB-1];
                    r_ret   <= S_RSAT;
                    r_state <= S_DNEGN;
                end

                // saturate one coordinate of the result
                S_RSAT: begin
                    if (!r_j) begin
                        r_rx    <= osat.val;
                        r_j     <= 1'b1;
                        r_state <= r_isx ? S_XMUL : S_VX;
                    end else begin
                        r_ry    <= osat.val;
                        r_state <= S_EMIT;
                    end
                    r_rovf <= r_rovf | osat.ovf;
                end

                // hand the word to the output register
                S_EMIT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_ox     <= r_rx;
                        r_oy     <= r_ry;
                        r_oclip  <= r_isx;
                        r_oovf   <= r_rovf;
                        r_olast  <= !(r_c1 || r_c2 || r_c3);
                        r_state  <= S_DISPATCH;
                    end
                end

                // shift-add multiply, signed 64-bit multiplier
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= alu_sum[WIDE-1:0];
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 7'd1;
                    if (r_cnt == 7'(MUL_STEPS - 1)) begin
                        r_state <= r_ret;
                    end
                end

                // truncating divide on magnitudes
                S_DNEGN: begin
                    if (r_nsign) begin
                        r_quo <= alu_sum[WIDE-1:0];
                    end
                    r_state <= S_DNEGD;
                end
                S_DNEGD: begin
                    if (r_dvs == '0) begin
                        // zero divisor: saturate by numerator sign
                        if (r_quo != '0) begin
                            r_quo <= r_nsign ? DZ_NEG : DZ_POS;
                        end
                        r_state <= r_ret;
                    end else begin
                        if (r_dvs[WIDE-1]) begin
                            r_dvs <= alu_sum[WIDE-1:0];
                        end
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DLOOP;
                    end
                end
                S_DLOOP: begin
                    if (alu_sum[WIDE]) begin
                        r_rem <= alu_sum[WIDE-1:0];
                        r_quo <= {r_quo[WIDE-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[WIDE-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'(DIV_STEPS - 1)) begin
                        r_state <= S_DFIX;
                    end
                end
                S_DFIX: begin
                    if (r_dneg) begin
                        r_quo <= alu_sum[WIDE-1:0];
                    end
                    r_state <= r_ret;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/ppnc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppnc_checker
// Port-level assertions for the projective transform and clipping block.
// ----------------------------------------------------------------------------
module ppnc_checker #(
    parameter int COORD_WIDTH = 32,
    localparam int TDW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           s_axis_tvalid,
    input wire logic           s_axis_tready,
    input wire logic           m_axis_tvalid,
    input wire logic           m_axis_tready,
    input wire logic [TDW-1:0] m_axis_tdata,  // out_x, out_y
    input wire logic [1:0]     m_axis_tuser,  // from_clip, overflow
    input wire logic           m_axis_tlast   // run_end
);

    // reset leaves the block idle with nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("not idle after reset");

    // one vertex at a time: busy right after accepting a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a word that is not the last of its vertex means work remains
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
        else $error("input ready before run end");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("output word changed under stall");

endmodule

bind polygon_project_near_clip ppnc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppnc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the projective vertex transform with near-plane
// clipping. A local predictor keeps its own matrix, near value and shape
// state, and it queues the expected points of every accepted vertex. A
// checker compares each output word, field by field, with the oldest
// expected point. Both stream sides idle and stall at random. One
// long output hold fills the block so that it backs up its input.
// ----------------------------------------------------------------------------
module tb_top;
    import ppnc_pkg::*;

    typedef logic signed [127:0] w128;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        clip;
        logic        ovf;
        logic        last;
    } point_t;

    localparam int SETTLE  = 2100;   // worst vertex latency plus margin
    localparam int WD_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    polygon_project_near_clip dut (.*);

    // predictor copies of registers and shape state
    logic [63:0] mtx_xx_xy, mtx_xo_yx, mtx_yy_yo, mtx_wx_wy;
    logic [31:0] mtx_wo;
    logic [16:0] near_w;
    w128 fst_h [3];
    w128 prv_h [3];
    logic fst_vis, prv_vis, fst_ovf, prv_ovf;

    point_t expected_pts[$];
    int  n_verts_sent, n_points, n_clip_pts, n_ovf_pts, n_mismatch, wd_count;
    bit  idle_en = 1'b1;
    int  hold_req = 0;

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // saturate to n signed bits
    function automatic w128 sat_to(input w128 v, input int n, inout logic ovf);
        w128 hi, lo;
        hi = (w128'(1) <<< (n - 1)) - 1;
        lo = -(w128'(1) <<< (n - 1));
        if (v > hi) begin
            ovf = 1'b1;
            return hi;
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // truncating division, saturated to 32 bits; zero divisor saturates by sign
    function automatic logic [31:0] div_coord(input w128 n, input w128 d, inout logic ovf);
        w128 q;
        if (d == 0) begin
            if (n == 0) return 32'd0;
            ovf = 1'b1;
            return (n < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        q = n / d;
        q = sat_to(q, 32, ovf);
        return q[31:0];
    endfunction

    function automatic w128 coef(input logic [31:0] c);
        return w128'(signed'(c));
    endfunction

    function automatic w128 homog(input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input w128 x, input w128 y,
                                  inout logic ovf);
        w128 s;
        s = ((coef(a) * x) + (coef(b) * y)) >>> 16;
        return sat_to(s + coef(c), HB, ovf);
    endfunction

    // intersection of edge a->b with the near plane
    function automatic point_t cross_pt(input w128 a [3], input w128 b [3], input logic ovf);
        point_t p;
        w128 nw, num, den, q;
        logic [31:0] r [2];
        nw  = w128'(near_w);
        num = a[2] - nw;
        den = a[2] - b[2];
        for (int j = 0; j < 2; j++) begin
            q = a[j] + ((b[j] - a[j]) * num) / den;
            r[j] = div_coord(q <<< 16, nw, ovf);
        end
        p.x = r[0]; p.y = r[1]; p.clip = 1'b1; p.ovf = ovf; p.last = 1'b0;
        return p;
    endfunction

    // predict the points one vertex yields and advance the shape state
    task automatic project_vertex(input logic [31:0] vx, input logic [31:0] vy,
                                  input bit first, input bit last, input bit closed);
        w128 x, y;
        w128 cur [3];
        logic hov, vis, o;
        point_t p;
        point_t pts[$];
        x = coef(vx);
        y = coef(vy);
        hov = 1'b0;
        cur[0] = homog(mtx_xx_xy[63:32], mtx_xx_xy[31:0], mtx_xo_yx[63:32], x, y, hov);
        cur[1] = homog(mtx_xo_yx[31:0], mtx_yy_yo[63:32], mtx_yy_yo[31:0], x, y, hov);
        cur[2] = homog(mtx_wx_wy[63:32], mtx_wx_wy[31:0], mtx_wo, x, y, hov);
        vis = (cur[2] >= w128'(near_w));
        if (!first && vis != prv_vis) pts.push_back(cross_pt(prv_h, cur, hov | prv_ovf));
        if (vis) begin
            o = hov;
            p.x = div_coord(cur[0] <<< 16, cur[2], o);
            p.y = div_coord(cur[1] <<< 16, cur[2], o);
            p.clip = 1'b0; p.ovf = o; p.last = 1'b0;
            pts.push_back(p);
        end
        if (first) begin
            fst_h = cur; fst_vis = vis; fst_ovf = hov;
        end
        if (last && closed && vis != fst_vis)
            pts.push_back(cross_pt(cur, fst_h, hov | fst_ovf));
        prv_h = cur; prv_vis = vis; prv_ovf = hov;
        if (pts.size() > 0) pts[pts.size() - 1].last = 1'b1;
        foreach (pts[k]) expected_pts.push_back(pts[k]);
    endtask

    // offer one vertex word, wait for acceptance, then predict
    task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                               input bit first, input bit last, input bit closed);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tdata  <= {vy, vx};
        s_axis_tuser  <= {closed, first};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        project_vertex(vx, vy, first, last, closed);
        n_verts_sent++;
    endtask

    // stop offering, wait for all points, then let a silent vertex finish
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // write all six registers while the block is idle
    task automatic set_matrix(input logic [63:0] xx_xy, input logic [63:0] xo_yx,
                              input logic [63:0] yy_yo, input logic [63:0] wx_wy,
                              input logic [31:0] wo, input logic [16:0] nr);
        logic [63:0] vals [6];
        logic [CFG_IDX_W-1:0] idx [6];
        vals = '{xx_xy, xo_yx, yy_yo, wx_wy, {32'd0, wo}, {47'd0, nr}};
        idx  = '{CFG_XX_XY, CFG_XO_YX, CFG_YY_YO, CFG_WX_WY, CFG_WO, CFG_NEAR};
        drain();
        for (int k = 0; k < 6; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        mtx_xx_xy = xx_xy; mtx_xo_yx = xo_yx; mtx_yy_yo = yy_yo; mtx_wx_wy = wx_wy;
        mtx_wo = wo; near_w = nr;
    endtask

    function automatic logic [31:0] small_coord(input int range_q);
        return 32'($signed($urandom_range(0, 2 * range_q)) - range_q);
    endfunction

    // perspective matrix whose w crosses the near plane over a few units
    task automatic set_perspective(input logic [16:0] nr);
        set_matrix({32'($urandom_range(32768, 131072)), small_coord(16384)},
                   {small_coord(65536), small_coord(16384)},
                   {32'($urandom_range(32768, 131072)), small_coord(65536)},
                   {small_coord(24576), small_coord(24576)},
                   32'h0001_0000 + small_coord(16384), nr);
    endtask

    // random well-formed shape, 1..6 vertices
    task automatic send_shape(input int range_q);
        int  n;
        bit  closed;
        n = $urandom_range(1, 6);
        closed = 1'($urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
            if (range_q == 0)
                send_vertex($urandom, $urandom, k == 0, k == n - 1, closed);
            else
                send_vertex(small_coord(range_q), small_coord(range_q), k == 0,
                            k == n - 1, closed);
        end
    endtask

    // ---- tests ----
    task automatic test_reset_identity;
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 1, 0, 0);
        send_vertex(32'h0000_0000, 32'h0000_0000, 0, 0, 0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1);
    endtask

    task automatic test_overflow_extremes;
        set_matrix(64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000,
                   64'h8000_0000_7FFF_FFFF, 64'h0000_0000_0000_0000,
                   32'h0000_0001, 17'd1);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 1);
        send_vertex(32'h8000_0000, 32'h8000_0000, 0, 0, 1);
        send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 0, 1, 1);
        set_matrix('1, '1, '1, 64'h7FFF_FFFF_7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 1);
        send_vertex(32'h8000_0000, 32'h8000_0000, 0, 1, 1);
    endtask

    task automatic test_plane_crossings;
        // w = 1 + x, so the sign of x decides visibility
        set_matrix(64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000_0000_0000,
                   64'h0001_0000_0000_0000, 32'h0001_0000, 17'd65536);
        send_vertex(32'h0002_0000, 32'h0001_0000, 1, 0, 1);
        send_vertex(32'hFFFE_0000, 32'h0003_0000, 0, 0, 1);
        send_vertex(32'hFFFF_0000, 32'hFFFD_0000, 0, 0, 1);
        send_vertex(32'h0001_8000, 32'h0000_8000, 0, 1, 1);
        send_vertex(32'hFFFE_0000, 32'h0001_0000, 1, 0, 0);
        send_vertex(32'h0003_0000, 32'h0001_0000, 0, 1, 0);
        // lone closed vertex, then vertices with no shape started
        send_vertex(32'hFFFC_0000, 32'h0000_0000, 1, 1, 1);
        send_vertex(32'h0004_0000, 32'h0002_0000, 0, 0, 1);
        send_vertex(32'hFFFC_0000, 32'h0002_0000, 0, 1, 1);
    endtask

    task automatic test_zero_near;
        set_matrix(64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000_0000_0000,
                   64'h0001_0000_0000_0000, 32'h0, 17'd0);
        send_vertex(32'h0000_0000, 32'h0000_0000, 1, 0, 1);
        send_vertex(32'hFFFF_0000, 32'h0001_0000, 0, 0, 1);
        send_vertex(32'h0002_0000, 32'hFFFF_0000, 0, 1, 1);
    endtask

    task automatic test_output_backpressure;
        set_perspective(17'd1311);
        hold_req = 3000;
        for (int k = 0; k < 3; k++) send_shape(4 << 16);
    endtask

    task automatic test_random_shapes;
        logic [16:0] nears [5];
        nears = '{17'd1, 17'd1311, 17'd65536, 17'd0, 17'($urandom_range(1, 65536))};
        for (int ph = 0; ph < 5; ph++) begin
            set_perspective(nears[ph]);
            for (int k = 0; k < 15; k++) begin
                case ($urandom_range(0, 9))
                    0: send_vertex($urandom, $urandom, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    1: send_shape(0);
                    default: send_shape(8 << 16);
                endcase
            end
        end
        // last part without idling
        idle_en = 1'b0;
        set_perspective(17'd1311);
        for (int k = 0; k < 10; k++) send_shape(8 << 16);
    endtask

    // ---- output checker ----
    always @(posedge i_clk) begin
        point_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_points++;
            if (expected_pts.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: unexpected point x=%h y=%h", $realtime,
                             m_axis_tdata[31:0], m_axis_tdata[63:32]);
            end else begin
                e = expected_pts.pop_front();
                if (e.clip) n_clip_pts++;
                if (e.ovf) n_ovf_pts++;
                if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y ||
                    m_axis_tuser[0] !== e.clip || m_axis_tuser[1] !== e.ovf ||
                    m_axis_tlast !== e.last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: mismatch exp x=%h y=%h clip=%b ovf=%b end=%b",
                                 $realtime, e.x, e.y, e.clip, e.ovf, e.last,
                                 " / got x=%h y=%h clip=%b ovf=%b end=%b",
                                 m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
                end
            end
        end
    end

    // output ready: long holds on request, random stall bursts otherwise
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
                m_axis_tready <= 1'b1;
            end else if (idle_en && i_rst_n && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", WD_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // main sequence
    initial begin
        n_verts_sent = 0; n_points = 0; n_clip_pts = 0; n_ovf_pts = 0;
        n_mismatch = 0; wd_count = 0;
        mtx_xx_xy = 64'h0001_0000_0000_0000; mtx_xo_yx = '0;
        mtx_yy_yo = 64'h0001_0000_0000_0000; mtx_wx_wy = '0;
        mtx_wo = 32'h0001_0000; near_w = 17'd1311;
        fst_h = '{0, 0, 0}; prv_h = '{0, 0, 0};
        fst_vis = 0; prv_vis = 0; fst_ovf = 0; prv_ovf = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_identity();
        test_overflow_extremes();
        test_plane_crossings();
        test_zero_near();
        test_output_backpressure();
        test_random_shapes();
        drain();
        $display("ran %0d vertices through 12 matrix settings: %0d points,",
                 n_verts_sent, n_points, " %0d clipped, %0d saturated",
                 n_clip_pts, n_ovf_pts);
        $display("%0d mismatches, %0d points still expected", n_mismatch,
                 expected_pts.size());
        if (n_mismatch == 0 && expected_pts.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
src/ppnc_pkg.sv
src/polygon_project_near_clip.sv
src/ppnc_checker.sv
tb/tb_top.sv
